[src/jp2bd_pkg.sv]
package jp2bd_pkg;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_XL   = 2'd2,
    PH_PAY  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_SHORT = 2'd2,
    ST_HALT  = 2'd3
  } status_e;

  localparam logic [63:0] HDR_BASIC = 64'd8;
  localparam logic [63:0] HDR_EXT   = 64'd16;
  localparam logic [63:0] LBOX_EXT  = 64'd1;
  localparam logic [2:0]  LBOX_LAST = 3'd3;
  localparam logic [2:0]  TBOX_LAST = 3'd3;
  localparam logic [2:0]  XL_LAST   = 3'd7;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  hdr_cnt;
    logic [63:0] len;
    logic [31:0] typ;
    logic [63:0] remain;
    logic        halted;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        in_payload;
    logic [31:0] box_type;
    logic [63:0] box_length;
    logic        header_done;
    logic        payload_first;
    logic        box_last;
    status_e     status;
  } result_t;

endpackage

[src/jp2bd_step.sv]
module jp2bd_step
  import jp2bd_pkg::*;
(
  input  parse_state_t st_i,
  input  logic [7:0]   byte_i,
  output parse_state_t st_o,
  output result_t      res_o
);

  logic        fin;
  logic [63:0] fin_hdr;
  logic [63:0] len_new;
  logic [31:0] typ_new;

  always_comb begin
    st_o    = st_i;
    res_o   = '0;
    res_o.byte_value = byte_i;
    res_o.status     = ST_OK;
    fin     = 1'b0;
    fin_hdr = HDR_BASIC;
    typ_new = {st_i.typ[23:0], byte_i};
    len_new = {st_i.len[55:0], byte_i};

    if (st_i.halted) begin
      res_o.status = ST_HALT;
    end else begin
      case (st_i.phase)
        PH_TYPE: begin
          st_o.typ = typ_new;
          res_o.box_length = (st_i.len == LBOX_EXT) ? 64'd0 : st_i.len;
          if (st_i.hdr_cnt == TBOX_LAST) begin
            st_o.hdr_cnt = 3'd0;
            if (st_i.len == LBOX_EXT) begin
              res_o.box_type = typ_new;
              st_o.len       = 64'd0;
              st_o.phase     = PH_XL;
            end else begin
              fin     = 1'b1;
              fin_hdr = HDR_BASIC;
            end
          end else begin
            st_o.hdr_cnt = 3'(st_i.hdr_cnt + 3'd1);
          end
        end
        PH_XL: begin
          st_o.len = len_new;
          res_o.box_type = st_i.typ;
          if (st_i.hdr_cnt == XL_LAST) begin
            st_o.hdr_cnt = 3'd0;
            fin     = 1'b1;
            fin_hdr = HDR_EXT;
          end else begin
            st_o.hdr_cnt = 3'(st_i.hdr_cnt + 3'd1);
          end
        end
        PH_PAY: begin
          res_o.in_payload    = 1'b1;
          res_o.box_type      = st_i.typ;
          res_o.box_length    = st_i.len;
          res_o.payload_first = (st_i.hdr_cnt == 3'd1);
          st_o.hdr_cnt = 3'd0;
          st_o.remain  = st_i.remain - 64'd1;
          if (st_i.remain == 64'd1) begin
            res_o.box_last = 1'b1;
            st_o.phase     = PH_LEN;
            st_o.len       = 64'd0;
            st_o.typ       = 32'd0;
            st_o.remain    = 64'd0;
          end
        end
        default: begin
          // lbox is 32 bits, upper half stays clear
          st_o.len = {32'd0, st_i.len[23:0], byte_i};
          if (st_i.hdr_cnt == LBOX_LAST) begin
            st_o.hdr_cnt = 3'd0;
            if (st_o.len == 64'd0) begin
              res_o.status = ST_END;
              st_o.halted  = 1'b1;
            end else begin
              res_o.box_length = (st_o.len == LBOX_EXT) ? 64'd0 : st_o.len;
              st_o.phase = PH_TYPE;
            end
          end else begin
            st_o.hdr_cnt = 3'(st_i.hdr_cnt + 3'd1);
            st_o.phase   = PH_LEN;
          end
        end
      endcase

      // header complete: check length against header size
      if (fin) begin
        res_o.box_type    = st_o.typ;
        res_o.box_length  = st_o.len;
        res_o.header_done = 1'b1;
        if (st_o.len < fin_hdr) begin
          res_o.status = ST_SHORT;
          st_o.halted  = 1'b1;
        end else if (st_o.len == fin_hdr) begin
          res_o.box_last = 1'b1;
          st_o.phase     = PH_LEN;
          st_o.hdr_cnt   = 3'd0;
          st_o.len       = 64'd0;
          st_o.typ       = 32'd0;
          st_o.remain    = 64'd0;
        end else begin
          st_o.phase   = PH_PAY;
          st_o.hdr_cnt = 3'd1;
          st_o.remain  = st_o.len - fin_hdr;
        end
      end
    end
  end

endmodule

[src/jp2_box_header_deframer_top.sv]
// jp2 box header deframer
// takes a jp2 file stream one byte word at a time on the in channel
// (in_valid_i / in_stall_o / data_byte_i) and gives one result word per byte
// on the out channel (out_valid_o / out_stall_i and the result fields)
// each result echoes the byte, tags it header or payload, and carries the
// current box type and length plus header_done, payload_first and box_last
// a zero lbox ends parsing (status 1); a length below the header size is
// flagged (status 2); after either, every byte returns status 3 until reset
// a byte taken is held in the input register, then the parse step writes its
// result into the result register
// throughput: one byte per clock while out_stall_i is low; the parse step is
// combinational, so consecutive bytes flow back to back
// when out_stall_i is high the result holds; the input register takes one
// more byte if it is empty, then in_stall_o rises until the result is taken
// reset (rst_ni low, async) empties both registers and returns the parser
// to the start of a box with no halt
module jp2_box_header_deframer_top
  import jp2bd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_value_o,
  output logic        in_payload_o,
  output logic [31:0] box_type_o,
  output logic [63:0] box_length_o,
  output logic        header_done_o,
  output logic        payload_first_o,
  output logic        box_last_o,
  output logic [1:0]  status_o
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  parse_state_t st_q, st_d;
  result_t      res_d, res_q;
  logic         out_valid_q;
  logic         out_free;
  logic         load_out;
  logic         in_take;

  jp2bd_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      st_q.phase     <= PH_LEN;
      st_q.hdr_cnt   <= 3'd0;
      st_q.len       <= 64'd0;
      st_q.typ       <= 32'd0;
      st_q.remain    <= 64'd0;
      st_q.halted    <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (load_out) begin
        in_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
    end
    if (load_out) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_value_o    = res_q.byte_value;
  assign in_payload_o    = res_q.in_payload;
  assign box_type_o      = res_q.box_type;
  assign box_length_o    = res_q.box_length;
  assign header_done_o   = res_q.header_done;
  assign payload_first_o = res_q.payload_first;
  assign box_last_o      = res_q.box_last;
  assign status_o        = res_q.status;

endmodule

[sim/box_tag_checker.sv]
`timescale 1ns / 1ps

// watches both channels, predicts the tag word of every byte taken and
// compares it with the word that leaves the deframer
module box_tag_checker
  import jp2bd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  byte_value_o,
  input  logic        in_payload_o,
  input  logic [31:0] box_type_o,
  input  logic [63:0] box_length_o,
  input  logic        header_done_o,
  input  logic        payload_first_o,
  input  logic        box_last_o,
  input  logic [1:0]  status_o,
  output int          fail_count_o,
  output int          pending_o
);

  // parser copy
  phase_e      ph;
  logic [2:0]  hcnt;
  logic [63:0] len_acc;
  logic [31:0] typ_acc;
  logic [63:0] remain;
  logic        stopped;

  result_t     tag_q[$];
  int          mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic new_box();
    ph      = PH_LEN;
    hcnt    = '0;
    len_acc = '0;
    typ_acc = '0;
    remain  = '0;
  endtask

  task automatic close_header(input logic [63:0] hdr, inout result_t r);
    r.box_type    = typ_acc;
    r.box_length  = len_acc;
    r.header_done = 1'b1;
    if (len_acc < hdr) begin
      r.status = ST_SHORT;
      stopped  = 1'b1;
    end else begin
      remain = len_acc - hdr;
      if (remain == '0) begin
        r.box_last = 1'b1;
        new_box();
      end else begin
        ph   = PH_PAY;
        hcnt = 3'd1;
      end
    end
  endtask

  task automatic tag_byte(input logic [7:0] b, output result_t r);
    r            = '0;
    r.byte_value = b;
    r.status     = ST_OK;
    if (stopped) begin
      r.status = ST_HALT;
    end else begin
      case (ph)
        PH_TYPE: begin
          typ_acc      = {typ_acc[23:0], b};
          r.box_length = (len_acc == LBOX_EXT) ? '0 : len_acc;
          if (hcnt == TBOX_LAST) begin
            hcnt = '0;
            if (len_acc == LBOX_EXT) begin
              r.box_type = typ_acc;
              len_acc    = '0;
              ph         = PH_XL;
            end else begin
              close_header(HDR_BASIC, r);
            end
          end else begin
            hcnt++;
          end
        end
        PH_XL: begin
          len_acc    = {len_acc[55:0], b};
          r.box_type = typ_acc;
          if (hcnt == XL_LAST) begin
            hcnt = '0;
            close_header(HDR_EXT, r);
          end else begin
            hcnt++;
          end
        end
        PH_PAY: begin
          r.in_payload    = 1'b1;
          r.box_type      = typ_acc;
          r.box_length    = len_acc;
          r.payload_first = (hcnt == 3'd1);
          hcnt            = '0;
          remain--;
          if (remain == '0) begin
            r.box_last = 1'b1;
            new_box();
          end
        end
        default: begin
          len_acc = {32'd0, len_acc[23:0], b};
          if (hcnt == LBOX_LAST) begin
            hcnt = '0;
            if (len_acc == '0) begin
              r.status = ST_END;
              stopped  = 1'b1;
            end else begin
              r.box_length = (len_acc == LBOX_EXT) ? '0 : len_acc;
              ph           = PH_TYPE;
            end
          end else begin
            hcnt++;
            ph = PH_LEN;
          end
        end
      endcase
    end
  endtask

  initial begin
    mismatches = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      new_box();
      stopped = 1'b0;
      tag_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.byte_value    = byte_value_o;
        got.in_payload    = in_payload_o;
        got.box_type      = box_type_o;
        got.box_length    = box_length_o;
        got.header_done   = header_done_o;
        got.payload_first = payload_first_o;
        got.box_last      = box_last_o;
        got.status        = status_e'(status_o);
        if (tag_q.size() == 0) begin
          report_mismatch("unexpected word, byte", 64'(got.byte_value), '0);
        end else begin
          want = tag_q.pop_front();
          if (got.byte_value != want.byte_value)
            report_mismatch("byte_value", 64'(got.byte_value), 64'(want.byte_value));
          if (got.in_payload != want.in_payload)
            report_mismatch("in_payload", 64'(got.in_payload), 64'(want.in_payload));
          if (got.box_type != want.box_type)
            report_mismatch("box_type", 64'(got.box_type), 64'(want.box_type));
          if (got.box_length != want.box_length)
            report_mismatch("box_length", got.box_length, want.box_length);
          if (got.header_done != want.header_done)
            report_mismatch("header_done", 64'(got.header_done), 64'(want.header_done));
          if (got.payload_first != want.payload_first)
            report_mismatch("payload_first", 64'(got.payload_first),
                            64'(want.payload_first));
          if (got.box_last != want.box_last)
            report_mismatch("box_last", 64'(got.box_last), 64'(want.box_last));
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        tag_byte(data_byte_i, want);
        tag_q.push_back(want);
      end
      pending_o <= tag_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
  import jp2bd_pkg::*;
();

  localparam int RANDOM_BYTES = 1400;
  localparam int CALM_TAIL    = 150;
  localparam int SQUEEZE_AT   = 500;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT        = 400000;
  localparam int TRAIL_BYTES  = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  byte_value_o;
  logic        in_payload_o;
  logic [31:0] box_type_o;
  logic [63:0] box_length_o;
  logic        header_done_o;
  logic        payload_first_o;
  logic        box_last_o;
  logic [1:0]  status_o;
  int          fail_count;
  int          pending;

  logic [7:0]  file_bytes[$];
  int          sent;
  int          gap_left;
  int          stall_left;
  bit          calm;
  bit          squeezing;
  bit          squeezed;

  jp2_box_header_deframer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_value_o   (byte_value_o),
    .in_payload_o   (in_payload_o),
    .box_type_o     (box_type_o),
    .box_length_o   (box_length_o),
    .header_done_o  (header_done_o),
    .payload_first_o(payload_first_o),
    .box_last_o     (box_last_o),
    .status_o       (status_o)
  );

  box_tag_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_value_o   (byte_value_o),
    .in_payload_o   (in_payload_o),
    .box_type_o     (box_type_o),
    .box_length_o   (box_length_o),
    .header_done_o  (header_done_o),
    .payload_first_o(payload_first_o),
    .box_last_o     (box_last_o),
    .status_o       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // header bytes of one box, then npay random content bytes
  task automatic push_box(input logic [63:0] total, input bit ext,
                          input logic [31:0] typ, input int npay);
    if (ext) begin
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h01);
    end else begin
      for (int i = 3; i >= 0; i--) file_bytes.push_back(total[i*8 +: 8]);
    end
    for (int i = 3; i >= 0; i--) file_bytes.push_back(typ[i*8 +: 8]);
    if (ext)
      for (int i = 7; i >= 0; i--) file_bytes.push_back(total[i*8 +: 8]);
    for (int i = 0; i < npay; i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic build_file();
    int          pick;
    int          npay;
    int          start;
    logic [63:0] huge;
    // header-only boxes of both header sizes, and a one-byte payload
    push_box(HDR_BASIC, 1'b0, 32'hFFFF_FFFF, 0);
    push_box(HDR_BASIC + 1, 1'b0, 32'h0000_0000, 1);
    push_box(HDR_EXT, 1'b1, 32'h6A50_2020, 0);
    start = file_bytes.size();
    while (file_bytes.size() < start + RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      npay = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      case (pick)
        0:       push_box(HDR_BASIC, 1'b0, $urandom, 0);
        1:       push_box(HDR_EXT, 1'b1, $urandom, 0);
        2, 3:    push_box(HDR_EXT + npay, 1'b1, $urandom, npay);
        default: push_box(HDR_BASIC + npay, 1'b0, $urandom, npay);
      endcase
    end
    // the run ends on one halting case, or on a box too long to finish
    case ($urandom_range(0, 3))
      0: begin
        for (int i = 0; i < 4; i++) file_bytes.push_back(8'h00);
        for (int i = 0; i < TRAIL_BYTES; i++) file_bytes.push_back(8'($urandom));
      end
      1: begin
        push_box(64'($urandom_range(2, 7)), 1'b0, $urandom, 0);
        for (int i = 0; i < TRAIL_BYTES; i++) file_bytes.push_back(8'($urandom));
      end
      2: begin
        push_box(64'($urandom_range(0, 15)), 1'b1, $urandom, 0);
        for (int i = 0; i < TRAIL_BYTES; i++) file_bytes.push_back(8'($urandom));
      end
      default: begin
        huge = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
        push_box(huge, 1'b1, $urandom, 40);
      end
    endcase
  endtask

  // receiver side: random stall bursts, one long hold-off mid run
  initial begin
    out_stall_i <= 1'b0;
    stall_left = 0;
    squeezing  = 1'b0;
    squeezed   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!squeezed && sent >= SQUEEZE_AT) begin
        squeezed  = 1'b1;
        squeezing = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        squeezing = 1'b0;
      end else if (stall_left > 0 && !calm) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && rst_ni && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 14);
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    sent     = 0;
    gap_left = 0;
    calm     = 1'b0;
    build_file();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent < file_bytes.size()) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) sent++;
      calm = (sent + CALM_TAIL >= file_bytes.size());
      if (in_valid_i && in_stall_o) begin
        // word held until taken
      end else if (gap_left > 0 && !calm && !squeezing) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (sent < file_bytes.size()) begin
        in_valid_i  <= 1'b1;
        data_byte_i <= file_bytes[sent];
        if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end

    // every word taken must come back before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/jp2bd_pkg.sv
src/jp2bd_step.sv
src/jp2_box_header_deframer_top.sv
sim/box_tag_checker.sv
sim/tb_top.sv
